[rtl/mpth_pkg.sv]
// Package: shared constants for the MAC pair Toeplitz hash unit.
`timescale 1ns / 1ps
`default_nettype none

package mpth_pkg;

  localparam int KEY_BITS        = 64;   // key bits used, from the top of the register
  localparam int KEY_REG_BITS    = 64;
  localparam int HASH_BITS       = 32;
  localparam int MAC_BYTES       = 6;
  localparam int HASHED_BYTES    = 2 * MAC_BYTES;
  localparam int MIN_FRAME_BYTES = 14;
  localparam int POS_BITS        = 4;
  localparam int CNT_BITS        = POS_BITS + 1;
  // key bits that one byte can touch: eight windows, each one bit further on
  localparam int SEG_BITS        = HASH_BITS + 7;

  localparam logic [POS_BITS-1:0]     POS_SAT    = POS_BITS'(14);
  localparam logic [KEY_REG_BITS-1:0] KEY_RESET  = 64'h6D5A_56FA_6D5A_56FA;

endpackage

`default_nettype wire

[rtl/mpth_if.sv]
// Interfaces: frame byte, hash result and key write channels.
`timescale 1ns / 1ps
`default_nettype none

interface mpth_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mpth_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;
  logic        short_frame;

  modport source (output valid, output hash_value, output short_frame, input ready);
  modport sink   (input valid, input hash_value, input short_frame, output ready);
endinterface

interface mpth_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_key;

  modport source (output valid, output hash_key, input ready);
  modport sink   (input valid, input hash_key, output ready);
endinterface

`default_nettype wire

[rtl/mpth_contrib.sv]
// Hash contribution of one frame byte: key segment select and window XOR.
`timescale 1ns / 1ps
`default_nettype none

module mpth_contrib (
  input  logic [mpth_pkg::KEY_REG_BITS-1:0] key,
  input  logic [mpth_pkg::POS_BITS-1:0]     pos,
  input  logic [7:0]                        data,
  output logic [mpth_pkg::HASH_BITS-1:0]    contrib
);
  import mpth_pkg::*;

  // seg[i] is key bit (base + i), base being the string offset of this byte
  logic [SEG_BITS-1:0] seg;

  always_comb begin
    int base;
    seg  = '0;
    base = 0;
    for (int p = 0; p < HASHED_BYTES; p++) begin
      // source MAC leads the string, destination MAC follows
      base = (p < MAC_BYTES) ? 8 * MAC_BYTES + 8 * p : 8 * (p - MAC_BYTES);
      if (pos == POS_BITS'(p)) begin
        for (int i = 0; i < SEG_BITS; i++) begin
          seg[i] = key[KEY_REG_BITS - 1 - ((base + i) % KEY_BITS)];
        end
      end
    end
  end

  // data bit 7-k selects the window starting k bits in; window MSB first
  always_comb begin
    contrib = '0;
    for (int t = 0; t < HASH_BITS; t++) begin
      for (int k = 0; k < 8; k++) begin
        contrib[HASH_BITS-1-t] = contrib[HASH_BITS-1-t] ^ (data[7-k] & seg[k+t]);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/mac_pair_toeplitz_hash_unit.sv]
// Top level: streaming Toeplitz hash over the source/destination MAC pair.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir   Payload                       Transfer when
// -------   ---   ---------------------------   -----------------------
// frame     in    data_byte[7:0], last_byte     frame.valid & frame.ready
// result    out   hash_value[31:0], short_frame result.valid & result.ready
// cfg       in    hash_key[63:0]                cfg.valid & cfg.ready (always ready)
//
// One byte per cycle sustained while results are taken. A byte sits in the input register,
// where the key segment mux and eight-window XOR fold it into the accumulator.
// The hash appears in the result register the cycle after the last byte is folded.
// The result register stalls only the last byte of a frame; other bytes keep flowing.
// Synchronous reset clears the pipeline valids, accumulator and byte count, and
// loads the default key.

module mac_pair_toeplitz_hash_unit (
  input  logic        clk,
  input  logic        rst,
  mpth_in_if.sink     frame,
  mpth_out_if.source  result,
  mpth_cfg_if.sink    cfg
);
  import mpth_pkg::*;

  // key register
  logic [KEY_REG_BITS-1:0] key;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // frame state
  logic [HASH_BITS-1:0] acc;
  logic [HASH_BITS-1:0] acc_next;
  logic [POS_BITS-1:0]  pos;
  logic [POS_BITS-1:0]  pos_next;
  logic [CNT_BITS-1:0]  count;
  logic [HASH_BITS-1:0] contrib;

  // result register
  logic                 out_valid;
  logic [HASH_BITS-1:0] out_hash;
  logic                 out_short;

  logic out_free;
  logic s1_go;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= KEY_RESET;
    end else if (cfg.valid) begin
      key <= cfg.hash_key;
    end
  end

  // only a last byte needs room in the result register
  assign out_free    = !out_valid || result.ready;
  assign s1_go       = s1_valid && (!s1_last || out_free);
  assign frame.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame.ready) begin
      s1_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.ready && frame.valid) begin
      s1_byte <= frame.data_byte;
      s1_last <= frame.last_byte;
    end
  end

  mpth_contrib u_contrib (
    .key     (key),
    .pos     (pos),
    .data    (s1_byte),
    .contrib (contrib)
  );

  // bytes past the address pair leave the hash alone
  assign acc_next = (pos < POS_BITS'(HASHED_BYTES)) ? (acc ^ contrib) : acc;
  assign count    = CNT_BITS'(pos) + CNT_BITS'(1);
  assign pos_next = (count > CNT_BITS'(POS_SAT)) ? POS_SAT : count[POS_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      pos <= '0;
    end else if (s1_go) begin
      if (s1_last) begin
        acc <= '0;
        pos <= '0;
      end else begin
        acc <= acc_next;
        pos <= pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      if (count < CNT_BITS'(MIN_FRAME_BYTES)) begin
        out_hash  <= '0;
        out_short <= 1'b1;
      end else begin
        out_hash  <= acc_next;
        out_short <= 1'b0;
      end
    end
  end

  assign result.valid       = out_valid;
  assign result.hash_value  = out_hash;
  assign result.short_frame = out_short;

  // short frames always report a zero hash
  a_short_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_short |-> out_hash == '0)
    else $error("short frame result with nonzero hash");

  // byte count saturates
  a_pos_sat : assert property (@(posedge clk) disable iff (rst)
    pos <= POS_SAT)
    else $error("byte position beyond saturation");

  // frame state restarts after the last byte
  a_frame_restart : assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_last |=> pos == '0 && acc == '0 && out_valid)
    else $error("frame state not cleared after last byte");

  // a stalled byte stays in the input register
  a_s1_hold : assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_byte) && $stable(s1_last))
    else $error("stalled frame byte lost");

  // a pending result is never overwritten
  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |-> !(s1_go && s1_last))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

[test/mac_pair_toeplitz_hash_unit_test.sv]
// Testbench: frame byte streams against a Toeplitz hash predictor across several keys.
`timescale 1ns / 1ps

module mac_pair_toeplitz_hash_unit_test;
  import mpth_pkg::*;

  // Run shape
  localparam int RANDOM_ITEMS  = 1650;
  localparam int KEY_PHASES    = 6;
  localparam int SETTLE_CYCLES = 4;       // byte register plus result register, with margin
  localparam int CYCLE_LIMIT   = 400_000; // watchdog bound, well above the slowest legal run
  localparam int DIRECTED_ROWS = 17;

  typedef struct packed {
    logic [HASH_BITS-1:0] hash_value;
    logic                 short_frame;
  } hash_result_t;

  // One directed byte. Rows marked fixed carry an expectation typed in by hand;
  // the rest take the predictor's answer.
  typedef struct packed {
    logic [7:0]   data_byte;
    logic         last_byte;
    logic         fixed;
    hash_result_t fixed_result;
  } frame_row_t;

  localparam frame_row_t DIRECTED[DIRECTED_ROWS] = '{
    // one-byte frame: shortest possible, all-zero data
    '{8'h00, 1'b1, 1'b1, '{32'h0, 1'b1}},
    // exactly fourteen bytes: broadcast destination, sparse source, two ignored tail bytes
    '{8'hFF, 1'b0, 1'b0, '{32'h0, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '{32'h0, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '{32'h0, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '{32'h0, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '{32'h0, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '{32'h0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, '{32'h0, 1'b0}},
    '{8'h11, 1'b0, 1'b0, '{32'h0, 1'b0}},
    '{8'h22, 1'b0, 1'b0, '{32'h0, 1'b0}},
    '{8'h80, 1'b0, 1'b0, '{32'h0, 1'b0}},
    '{8'h01, 1'b0, 1'b0, '{32'h0, 1'b0}},
    '{8'h55, 1'b0, 1'b0, '{32'h0, 1'b0}},
    '{8'h88, 1'b0, 1'b0, '{32'h0, 1'b0}},
    '{8'h47, 1'b1, 1'b0, '{32'h0, 1'b0}},
    // two-byte frame of all ones: still short, hash forced to zero
    '{8'hFF, 1'b0, 1'b0, '{32'h0, 1'b0}},
    '{8'hFF, 1'b1, 1'b1, '{32'h0, 1'b1}}
  };

  logic clk = 1'b0;
  logic rst;

  mpth_in_if  frame_bus ();
  mpth_out_if result_bus ();
  mpth_cfg_if key_bus ();

  mac_pair_toeplitz_hash_unit dut (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame_bus),
    .result (result_bus),
    .cfg    (key_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Hash predictor: its own key copy, XOR accumulator and byte position.
  // ---------------------------------------------------------------------------
  logic [KEY_REG_BITS-1:0] active_key   = KEY_RESET;
  logic [HASH_BITS-1:0]    mac_hash_acc = '0;
  int unsigned             frame_pos    = 0;

  hash_result_t pending_hashes[$];
  int           mismatch_count = 0;
  bit           idling_on      = 1'b1;
  int           cycle_count    = 0;

  // 32-bit key window starting at key bit 'start', MSB first, wrapping over
  // the top KEY_BITS bits of the key register.
  function automatic logic [HASH_BITS-1:0] toeplitz_window(input int unsigned start);
    logic [HASH_BITS-1:0] window;
    int unsigned          t;
    window = '0;
    for (t = 0; t < HASH_BITS; t++)
      window = {window[HASH_BITS-2:0], active_key[KEY_REG_BITS-1 - ((start + t) % KEY_BITS)]};
    return window;
  endfunction

  // Fold one accepted byte in; reports whether it closes a frame and with what.
  function automatic void fold_frame_byte(input logic [7:0] b, input logic last,
                                          output bit closes, output hash_result_t res);
    int unsigned base;
    int unsigned k;
    closes = 1'b0;
    res    = '0;
    if (frame_pos < HASHED_BYTES) begin
      // hashed string is source MAC first, so destination bytes start at bit 48
      base = (frame_pos < MAC_BYTES) ? 8 * (MAC_BYTES + frame_pos)
                                     : 8 * (frame_pos - MAC_BYTES);
      for (k = 0; k < 8; k++)
        if (b[7-k]) mac_hash_acc ^= toeplitz_window(base + k);
    end
    if (last) begin
      closes = 1'b1;
      if (frame_pos + 1 < MIN_FRAME_BYTES) res = '{hash_value: '0, short_frame: 1'b1};
      else                                 res = '{hash_value: mac_hash_acc, short_frame: 1'b0};
      mac_hash_acc = '0;
      frame_pos    = 0;
    end else begin
      frame_pos = (frame_pos + 1 > POS_SAT) ? POS_SAT : frame_pos + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Frame byte source. Valid stays high across back-to-back transfers and is
  // only dropped for an idle burst or when the sender goes quiet.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic last,
                           input bit fixed, input hash_result_t fixed_result);
    bit           closes;
    hash_result_t res;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      frame_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    frame_bus.valid     <= 1'b1;
    frame_bus.data_byte <= b;
    frame_bus.last_byte <= last;
    do @(posedge clk); while (!frame_bus.ready);
    fold_frame_byte(b, last, closes, res);
    if (closes) pending_hashes.push_back(fixed ? fixed_result : res);
  endtask

  task automatic send_random_frame(input int unsigned len);
    int unsigned  i;
    logic [7:0]   b;
    for (i = 0; i < len; i++) begin
      // lean on all-zero and all-one bytes, they hit every window or none
      case ($urandom_range(0, 5))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      send_byte(b, i == len - 1, 1'b0, '0);
    end
  endtask

  // Wait for every pending hash, then let the pipeline go quiet.
  task automatic drain_frames();
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_hash_key(input logic [KEY_REG_BITS-1:0] key);
    key_bus.valid    <= 1'b1;
    key_bus.hash_key <= key;
    do @(posedge clk); while (!key_bus.ready);
    active_key = key;
    key_bus.valid <= 1'b0;
  endtask

  // Result sink: ready drops in random bursts while idling is on.
  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idling_on && $urandom_range(0, 7) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
    end
  end

  // Every result transfer is checked against the oldest pending hash.
  always @(posedge clk) begin : check_hashes
    hash_result_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_hashes.size() == 0) begin
        $error("unexpected result: hash_value %h short_frame %b",
               result_bus.hash_value, result_bus.short_frame);
        mismatch_count++;
      end else begin
        want = pending_hashes.pop_front();
        if (result_bus.hash_value !== want.hash_value) begin
          $error("hash_value: expected %h, got %h", want.hash_value, result_bus.hash_value);
          mismatch_count++;
        end
        if (result_bus.short_frame !== want.short_frame) begin
          $error("short_frame: expected %b, got %b", want.short_frame, result_bus.short_frame);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table under the reset key, then random
  // frames in key phases. Keys change only between frames with nothing in
  // flight; the final phase runs with no idling on either side.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [KEY_REG_BITS-1:0] phase_keys[KEY_PHASES];
    int unsigned             phase_items;
    int unsigned             frame_len;
    int                      ph;
    int                      row;

    rst                 <= 1'b1;
    frame_bus.valid     <= 1'b0;
    frame_bus.data_byte <= '0;
    frame_bus.last_byte <= 1'b0;
    key_bus.valid       <= 1'b0;
    key_bus.hash_key    <= '0;

    // phase 0 keeps the reset key, so it is never written there
    phase_keys[0] = KEY_RESET;
    phase_keys[1] = '0;
    phase_keys[2] = '1;
    phase_keys[3] = {$urandom, $urandom};
    phase_keys[4] = 64'h8000_0000_0000_0001;
    phase_keys[5] = {$urandom, $urandom};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (row = 0; row < DIRECTED_ROWS; row++)
      send_byte(DIRECTED[row].data_byte, DIRECTED[row].last_byte,
                DIRECTED[row].fixed, DIRECTED[row].fixed_result);

    for (ph = 0; ph < KEY_PHASES; ph++) begin
      if (ph != 0) begin
        // sender holds off until the last hash is out, then the key changes
        frame_bus.valid <= 1'b0;
        drain_frames();
        write_hash_key(phase_keys[ph]);
      end
      idling_on   = (ph != KEY_PHASES - 1);
      phase_items = 0;
      while (phase_items < RANDOM_ITEMS / KEY_PHASES) begin
        // mostly full-size headers, with short and boundary lengths mixed in
        case ($urandom_range(0, 9))
          0, 1:    frame_len = $urandom_range(1, 13);
          2, 3:    frame_len = $urandom_range(12, 15);
          9:       frame_len = $urandom_range(25, 60);
          default: frame_len = $urandom_range(14, 24);
        endcase
        send_random_frame(frame_len);
        phase_items += frame_len;
      end
    end

    frame_bus.valid <= 1'b0;
    drain_frames();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
